FILE: hw/rtl/lpf_pkg.sv
package lpf_pkg;

    // Fixed-point widths: inputs Q2.14, internal monomials Q24, products Q16
    localparam int IN_W   = 16;
    localparam int Q_SH   = 24;
    localparam int MONO_W = 34;
    localparam int COEF_W = 32;
    localparam int PROD_W = 40;
    localparam int SUM_W  = 50;
    localparam int OUT_W  = 48;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;

    localparam int N_TERM = 20;
    localparam int N_COEF = 10;
    localparam int N_PART = 4;
    localparam int PART_LEN = N_TERM / N_PART;

    // Cycles from the accepting edge to the result strobe
    localparam int LATENCY = 8;

    typedef enum logic [1:0] {
        SEL_X    = 2'd0,
        SEL_Y    = 2'd1,
        SEL_Z    = 2'd2,
        SEL_NONE = 2'd3
    } t_sel;

    typedef enum logic [IDX_W-1:0] {
        REG_SEL   = 3'd0,
        REG_COEF1 = 3'd1,
        REG_COEF2 = 3'd2,
        REG_COEF3 = 3'd3,
        REG_COEF4 = 3'd4,
        REG_COEF5 = 3'd5
    } t_reg_idx;

    // Coefficient order: a1 a11 a12 a111 a112 a123 a1111 a1112 a1122 a1123
    localparam int C_A1    = 0;
    localparam int C_A11   = 1;
    localparam int C_A12   = 2;
    localparam int C_A111  = 3;
    localparam int C_A112  = 4;
    localparam int C_A123  = 5;
    localparam int C_A1111 = 6;
    localparam int C_A1112 = 7;
    localparam int C_A1122 = 8;
    localparam int C_A1123 = 9;

    typedef logic signed [MONO_W-1:0] t_mono;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // Q24 times Q24, round half up, back to Q24
    function automatic t_mono m24(input t_mono a, input t_mono b);
        logic signed [2*MONO_W-1:0] p;
        logic signed [2*MONO_W-1:0] bias;
        bias = '0;
        bias[Q_SH-1] = 1'b1;
        p = a * b;
        p = p + bias;
        return p[Q_SH +: MONO_W];
    endfunction

    // Q16.16 coefficient times Q24 monomial, round half up, to Q16
    function automatic t_prod cm24(input t_coef c, input t_mono m);
        logic signed [COEF_W+MONO_W-1:0] p;
        logic signed [COEF_W+MONO_W-1:0] bias;
        bias = '0;
        bias[Q_SH-1] = 1'b1;
        p = c * m;
        p = p + bias;
        return p[Q_SH +: PROD_W];
    endfunction

    // Coefficient used by each term of the derivative
    function automatic int coef_of(input int t);
        int c;
        case (t)
            0:       c = C_A1;
            1:       c = C_A11;
            2:       c = C_A111;
            3:       c = C_A1111;
            4, 5:    c = C_A12;
            6:       c = C_A123;
            7, 8, 9, 10:    c = C_A112;
            11, 12, 13, 14: c = C_A1112;
            15, 16:  c = C_A1122;
            default: c = C_A1123;
        endcase
        return c;
    endfunction

    // Integer weight of each term
    function automatic logic [3:0] weight_of(input int t);
        logic [3:0] w;
        case (t)
            1, 9, 10, 15, 16, 17: w = 4'd4;
            2, 13, 14:            w = 4'd6;
            3:                    w = 4'd8;
            default:              w = 4'd2;
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/lpf_power.sv
module lpf_power (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  lpf_pkg::t_sel                   i_sel,
    input  logic signed [lpf_pkg::IN_W-1:0] i_x,
    input  logic signed [lpf_pkg::IN_W-1:0] i_y,
    input  logic signed [lpf_pkg::IN_W-1:0] i_z,
    output logic                            o_valid,
    output lpf_pkg::t_mono                  o_mono [lpf_pkg::N_TERM]
);

    logic [4:0] r_vld;

    logic signed [lpf_pkg::IN_W-1:0] n_u, n_v, n_w;

    lpf_pkg::t_mono r0_u, r0_v, r0_w;
    lpf_pkg::t_mono r1_u, r1_u2, r1_v2, r1_w2;
    lpf_pkg::t_mono r2_u, r2_u2, r2_v2, r2_w2, r2_u3, r2_u4, r2_v4, r2_w4, r2_v2w2;
    lpf_pkg::t_mono r3_u, r3_u3, r3_v2, r3_w2, r3_v4, r3_w4, r3_v2w2;
    lpf_pkg::t_mono r3_u5, r3_u6, r3_v6, r3_w6, r3_v4w2, r3_v2w4;
    lpf_pkg::t_mono r_mono [lpf_pkg::N_TERM];

    // With no component selected u is zero, and every term carries u
    always_comb begin
        case (i_sel)
            lpf_pkg::SEL_X: begin
                n_u = i_x; n_v = i_y; n_w = i_z;
            end
            lpf_pkg::SEL_Y: begin
                n_u = i_y; n_v = i_x; n_w = i_z;
            end
            lpf_pkg::SEL_Z: begin
                n_u = i_z; n_v = i_x; n_w = i_y;
            end
            default: begin
                n_u = '0; n_v = i_x; n_w = i_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r0_u <= lpf_pkg::MONO_W'(signed'({n_u, 10'b0}));
        r0_v <= lpf_pkg::MONO_W'(signed'({n_v, 10'b0}));
        r0_w <= lpf_pkg::MONO_W'(signed'({n_w, 10'b0}));

        r1_u  <= r0_u;
        r1_u2 <= lpf_pkg::m24(r0_u, r0_u);
        r1_v2 <= lpf_pkg::m24(r0_v, r0_v);
        r1_w2 <= lpf_pkg::m24(r0_w, r0_w);

        r2_u    <= r1_u;
        r2_u2   <= r1_u2;
        r2_v2   <= r1_v2;
        r2_w2   <= r1_w2;
        r2_u3   <= lpf_pkg::m24(r1_u2, r1_u);
        r2_u4   <= lpf_pkg::m24(r1_u2, r1_u2);
        r2_v4   <= lpf_pkg::m24(r1_v2, r1_v2);
        r2_w4   <= lpf_pkg::m24(r1_w2, r1_w2);
        r2_v2w2 <= lpf_pkg::m24(r1_v2, r1_w2);

        r3_u    <= r2_u;
        r3_u3   <= r2_u3;
        r3_v2   <= r2_v2;
        r3_w2   <= r2_w2;
        r3_v4   <= r2_v4;
        r3_w4   <= r2_w4;
        r3_v2w2 <= r2_v2w2;
        r3_u5   <= lpf_pkg::m24(r2_u4, r2_u);
        r3_u6   <= lpf_pkg::m24(r2_u4, r2_u2);
        r3_v6   <= lpf_pkg::m24(r2_v4, r2_v2);
        r3_w6   <= lpf_pkg::m24(r2_w4, r2_w2);
        r3_v4w2 <= lpf_pkg::m24(r2_v4, r2_w2);
        r3_v2w4 <= lpf_pkg::m24(r2_v2, r2_w4);

        r_mono[0]  <= r3_u;
        r_mono[1]  <= r3_u3;
        r_mono[2]  <= r3_u5;
        r_mono[3]  <= lpf_pkg::m24(r3_u6, r3_u);
        r_mono[4]  <= lpf_pkg::m24(r3_u, r3_v2);
        r_mono[5]  <= lpf_pkg::m24(r3_u, r3_w2);
        r_mono[6]  <= lpf_pkg::m24(r3_u, r3_v2w2);
        r_mono[7]  <= lpf_pkg::m24(r3_u, r3_v4);
        r_mono[8]  <= lpf_pkg::m24(r3_u, r3_w4);
        r_mono[9]  <= lpf_pkg::m24(r3_u3, r3_v2);
        r_mono[10] <= lpf_pkg::m24(r3_u3, r3_w2);
        r_mono[11] <= lpf_pkg::m24(r3_u, r3_v6);
        r_mono[12] <= lpf_pkg::m24(r3_u, r3_w6);
        r_mono[13] <= lpf_pkg::m24(r3_u5, r3_v2);
        r_mono[14] <= lpf_pkg::m24(r3_u5, r3_w2);
        r_mono[15] <= lpf_pkg::m24(r3_u3, r3_v4);
        r_mono[16] <= lpf_pkg::m24(r3_u3, r3_w4);
        r_mono[17] <= lpf_pkg::m24(r3_u3, r3_v2w2);
        r_mono[18] <= lpf_pkg::m24(r3_u, r3_v4w2);
        r_mono[19] <= lpf_pkg::m24(r3_u, r3_v2w4);
    end

    assign o_valid = r_vld[4];
    assign o_mono  = r_mono;

endmodule

FILE: hw/rtl/lpf_coef.sv
module lpf_coef (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lpf_pkg::t_mono i_mono [lpf_pkg::N_TERM],
    input  lpf_pkg::t_coef i_coef [lpf_pkg::N_COEF],
    output logic           o_valid,
    output lpf_pkg::t_prod o_prod [lpf_pkg::N_TERM]
);

    logic           r_valid;
    lpf_pkg::t_prod r_prod [lpf_pkg::N_TERM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // One multiplier per term, each against the coefficient that coef_of names for it
    always_ff @(posedge i_clk) begin
        for (int t = 0; t < lpf_pkg::N_TERM; t++) begin
            r_prod[t] <= lpf_pkg::cm24(i_coef[lpf_pkg::coef_of(t)], i_mono[t]);
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

FILE: hw/rtl/lpf_sum.sv
module lpf_sum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  lpf_pkg::t_prod                      i_prod [lpf_pkg::N_TERM],
    output logic                                o_valid,
    output logic signed [lpf_pkg::OUT_W-1:0]    o_value,
    output logic                                o_sat
);

    logic [1:0]    r_vld;
    lpf_pkg::t_sum r_part [lpf_pkg::N_PART];
    lpf_pkg::t_sum n_part [lpf_pkg::N_PART];
    lpf_pkg::t_sum n_total;
    logic          n_ovf;

    logic signed [lpf_pkg::OUT_W-1:0] r_value, n_value;
    logic                             r_sat;

    // Weight each term and fold groups of terms into partial sums
    always_comb begin
        for (int p = 0; p < lpf_pkg::N_PART; p++) begin
            n_part[p] = '0;
            for (int k = 0; k < lpf_pkg::PART_LEN; k++) begin
                n_part[p] = n_part[p]
                    + lpf_pkg::SUM_W'(i_prod[p*lpf_pkg::PART_LEN + k])
                    * lpf_pkg::SUM_W'(signed'({1'b0,
                          lpf_pkg::weight_of(p*lpf_pkg::PART_LEN + k)}));
            end
        end
    end

    // Clip when the bits above the output sign disagree with it
    always_comb begin
        n_total = '0;
        for (int p = 0; p < lpf_pkg::N_PART; p++) begin
            n_total = n_total + r_part[p];
        end
        n_ovf = !((&n_total[lpf_pkg::SUM_W-1:lpf_pkg::OUT_W-1])
                || !(|n_total[lpf_pkg::SUM_W-1:lpf_pkg::OUT_W-1]));
        if (!n_ovf) begin
            n_value = n_total[lpf_pkg::OUT_W-1:0];
        end else if (n_total[lpf_pkg::SUM_W-1]) begin
            n_value = {1'b1, {(lpf_pkg::OUT_W-1){1'b0}}};
        end else begin
            n_value = {1'b0, {(lpf_pkg::OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_part  <= n_part;
        r_value <= n_value;
        r_sat   <= n_ovf;
    end

    assign o_valid = r_vld[1];
    assign o_value = r_value;
    assign o_sat   = r_sat;

endmodule

FILE: hw/rtl/landau_polarization_force.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------------
// command   | in        | start, busy          | i_pol_x, i_pol_y, i_pol_z (Q2.14)
// result    | out       | o_done strobe        | o_force_value (Q32.16), o_saturated_flag
// config    | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One transfer is accepted every cycle; busy stays low.
// Each result passes through eight register stages after its accepting edge:
// input, three power stages, monomials, coefficient
// products, partial sums, final sum with saturation.
// Reset clears the valid bits and all configuration registers.
// The receiver cannot stall, so the pipeline never holds.
module landau_polarization_force (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [lpf_pkg::IN_W-1:0]     i_pol_x,
    input  logic signed [lpf_pkg::IN_W-1:0]     i_pol_y,
    input  logic signed [lpf_pkg::IN_W-1:0]     i_pol_z,
    input  logic                                i_cfg_we,
    input  logic [lpf_pkg::IDX_W-1:0]           i_cfg_idx,
    input  logic [lpf_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                o_done,
    output logic signed [lpf_pkg::OUT_W-1:0]    o_force_value,
    output logic                                o_saturated_flag
);

    lpf_pkg::t_sel  r_sel;
    lpf_pkg::t_coef r_coef [lpf_pkg::N_COEF];

    logic           w_acc;
    logic           w_mono_vld;
    lpf_pkg::t_mono w_mono [lpf_pkg::N_TERM];
    logic           w_prod_vld;
    lpf_pkg::t_prod w_prod [lpf_pkg::N_TERM];

    // Never stall: every cycle can take a new command
    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    // Register writes; each 64-bit coefficient word carries two Q16.16 coefficients,
    // low half first. Indexes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= lpf_pkg::SEL_X;
            for (int c = 0; c < lpf_pkg::N_COEF; c++) begin
                r_coef[c] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lpf_pkg::REG_SEL: begin
                    r_sel <= lpf_pkg::t_sel'(i_cfg_data[1:0]);
                end
                lpf_pkg::REG_COEF1: begin
                    r_coef[0] <= i_cfg_data[31:0];
                    r_coef[1] <= i_cfg_data[63:32];
                end
                lpf_pkg::REG_COEF2: begin
                    r_coef[2] <= i_cfg_data[31:0];
                    r_coef[3] <= i_cfg_data[63:32];
                end
                lpf_pkg::REG_COEF3: begin
                    r_coef[4] <= i_cfg_data[31:0];
                    r_coef[5] <= i_cfg_data[63:32];
                end
                lpf_pkg::REG_COEF4: begin
                    r_coef[6] <= i_cfg_data[31:0];
                    r_coef[7] <= i_cfg_data[63:32];
                end
                lpf_pkg::REG_COEF5: begin
                    r_coef[8] <= i_cfg_data[31:0];
                    r_coef[9] <= i_cfg_data[63:32];
                end
                default: begin
                end
            endcase
        end
    end

    // Powers and monomials of the selected component against the other two
    lpf_power u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_sel   (r_sel),
        .i_x     (i_pol_x),
        .i_y     (i_pol_y),
        .i_z     (i_pol_z),
        .o_valid (w_mono_vld),
        .o_mono  (w_mono)
    );

    // Scale each monomial by its coefficient
    lpf_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mono_vld),
        .i_mono  (w_mono),
        .i_coef  (r_coef),
        .o_valid (w_prod_vld),
        .o_prod  (w_prod)
    );

    // Weighted sum, saturate to 48 bits, drive the result strobe
    lpf_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prod_vld),
        .i_prod  (w_prod),
        .o_valid (o_done),
        .o_value (o_force_value),
        .o_sat   (o_saturated_flag)
    );

    // A command transfer always yields its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##8 o_done)
        else $error("result strobe missing after command transfer");

    // No result without an earlier command transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, 8))
        else $error("result strobe without command transfer");

    // A clipped result sits at one end of the output range
    a_sat_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated_flag) |->
            (o_force_value == {1'b0, {(lpf_pkg::OUT_W-1){1'b1}}}
             || o_force_value == {1'b1, {(lpf_pkg::OUT_W-1){1'b0}}}))
        else $error("saturated result not at range end");

endmodule

FILE: dv/tb_landau_polarization_force.sv
module tb_landau_polarization_force;
    import lpf_pkg::*;

    // Register indexes past the last coefficient register; the block drops them
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [COEF_W-1:0] COEF_MAX  = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN  = 32'h8000_0000;
    localparam logic [COEF_W-1:0] COEF_ONE  = 32'h0001_0000;
    localparam logic [COEF_W-1:0] COEF_MONE = 32'hFFFF_0000;

    localparam longint FORCE_MAX = 64'sd140737488355327;
    localparam longint FORCE_MIN = -64'sd140737488355328;

    // One entry of the stimulus stream: either a register write or a
    // polarization vector, with the idle cycles that follow it
    typedef struct {
        bit                         is_cfg;
        logic [IDX_W-1:0]           idx;
        logic [CFG_W-1:0]           data;
        logic signed [IN_W-1:0]     px;
        logic signed [IN_W-1:0]     py;
        logic signed [IN_W-1:0]     pz;
        int                         gap;
    } t_stim;

    typedef struct {
        logic signed [OUT_W-1:0]    value;
        logic                       sat;
    } t_force;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [IN_W-1:0]     i_pol_x = '0;
    logic signed [IN_W-1:0]     i_pol_y = '0;
    logic signed [IN_W-1:0]     i_pol_z = '0;
    logic                       i_cfg_we = 1'b0;
    logic [IDX_W-1:0]           i_cfg_idx = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       o_done;
    logic signed [OUT_W-1:0]    o_force_value;
    logic                       o_saturated_flag;

    t_stim      stim_q[$];
    t_force     force_q[$];
    int         n_errors = 0;
    int         gap_left = 0;
    int         quiet_cycles = 0;

    // Shadow of the configuration registers as the block sees them
    logic [1:0]         sel_shadow = '0;
    logic [CFG_W-1:0]   coef_shadow[1:5] = '{default: '0};

    landau_polarization_force u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_pol_x          (i_pol_x),
        .i_pol_y          (i_pol_y),
        .i_pol_z          (i_pol_z),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_force_value    (o_force_value),
        .o_saturated_flag (o_saturated_flag)
    );

    always #6 i_clk = ~i_clk;

    // Q24 product with round half up; arithmetic shift floors
    function automatic longint q24_mul(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< 23);
        return p >>> 24;
    endfunction

    function automatic longint coef_half(input int r, input bit upper);
        logic [COEF_W-1:0] raw;
        raw = upper ? coef_shadow[r][63:32] : coef_shadow[r][31:0];
        return longint'(signed'(raw));
    endfunction

    // Energy derivative along u, with v and w the other two axes
    function automatic longint landau_slope(input longint pu, input longint pv,
                                            input longint pw);
        longint u1, u2, u3, u4, u5, u6, u7;
        longint v1, v2, v4, v6, w1, w2, w4, w6, v2w2, v4w2, v2w4;
        longint a1, a11, a12, a111, a112, a123, a1111, a1112, a1122, a1123;
        longint acc;
        u1 = pu * 1024; v1 = pv * 1024; w1 = pw * 1024;
        u2 = q24_mul(u1, u1); u3 = q24_mul(u2, u1); u4 = q24_mul(u2, u2);
        u5 = q24_mul(u4, u1); u6 = q24_mul(u4, u2); u7 = q24_mul(u6, u1);
        v2 = q24_mul(v1, v1); v4 = q24_mul(v2, v2); v6 = q24_mul(v4, v2);
        w2 = q24_mul(w1, w1); w4 = q24_mul(w2, w2); w6 = q24_mul(w4, w2);
        v2w2 = q24_mul(v2, w2); v4w2 = q24_mul(v4, w2); v2w4 = q24_mul(v2, w4);
        a1    = coef_half(1, 0); a11   = coef_half(1, 1);
        a12   = coef_half(2, 0); a111  = coef_half(2, 1);
        a112  = coef_half(3, 0); a123  = coef_half(3, 1);
        a1111 = coef_half(4, 0); a1112 = coef_half(4, 1);
        a1122 = coef_half(5, 0); a1123 = coef_half(5, 1);
        acc = 2 * q24_mul(a1, u1) + 4 * q24_mul(a11, u3)
            + 6 * q24_mul(a111, u5) + 8 * q24_mul(a1111, u7);
        acc += 2 * q24_mul(a12, q24_mul(u1, v2)) + 2 * q24_mul(a12, q24_mul(u1, w2));
        acc += 2 * q24_mul(a123, q24_mul(u1, v2w2));
        acc += 2 * q24_mul(a112, q24_mul(u1, v4)) + 2 * q24_mul(a112, q24_mul(u1, w4))
             + 4 * q24_mul(a112, q24_mul(u3, v2)) + 4 * q24_mul(a112, q24_mul(u3, w2));
        acc += 2 * q24_mul(a1112, q24_mul(u1, v6)) + 2 * q24_mul(a1112, q24_mul(u1, w6))
             + 6 * q24_mul(a1112, q24_mul(u5, v2)) + 6 * q24_mul(a1112, q24_mul(u5, w2));
        acc += 4 * q24_mul(a1122, q24_mul(u3, v4)) + 4 * q24_mul(a1122, q24_mul(u3, w4));
        acc += 4 * q24_mul(a1123, q24_mul(u3, v2w2))
             + 2 * q24_mul(a1123, q24_mul(u1, v4w2))
             + 2 * q24_mul(a1123, q24_mul(u1, v2w4));
        return acc;
    endfunction

    // Select the axis, then clip to the 48-bit output range
    function automatic t_force predict_force(input logic signed [IN_W-1:0] px,
                                             input logic signed [IN_W-1:0] py,
                                             input logic signed [IN_W-1:0] pz);
        t_force f;
        longint raw;
        case (t_sel'(sel_shadow))
            SEL_X:   raw = landau_slope(px, py, pz);
            SEL_Y:   raw = landau_slope(py, px, pz);
            SEL_Z:   raw = landau_slope(pz, px, py);
            default: raw = 0;
        endcase
        f.sat = 1'b0;
        if (raw > FORCE_MAX) begin
            raw = FORCE_MAX;
            f.sat = 1'b1;
        end else if (raw < FORCE_MIN) begin
            raw = FORCE_MIN;
            f.sat = 1'b1;
        end
        f.value = raw[OUT_W-1:0];
        return f;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [IN_W-1:0] pick_pol();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return IN_W'($urandom());
        endcase
    endfunction

    task automatic add_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        t_stim s;
        s = '{is_cfg: 1'b1, idx: idx, data: data, px: '0, py: '0, pz: '0, gap: 0};
        stim_q.push_back(s);
    endtask

    task automatic add_pol(input logic signed [IN_W-1:0] px,
                           input logic signed [IN_W-1:0] py,
                           input logic signed [IN_W-1:0] pz, input int gap);
        t_stim s;
        s = '{is_cfg: 1'b0, idx: '0, data: '0, px: px, py: py, pz: pz, gap: gap};
        stim_q.push_back(s);
    endtask

    // Select keeps only its low two bits; random upper bits must be ignored
    task automatic add_select(input t_sel sel);
        logic [CFG_W-1:0] d;
        d = {$urandom(), $urandom()};
        d[1:0] = sel;
        add_cfg(REG_SEL, d);
    endtask

    task automatic add_coef_set(input int mode);
        logic [COEF_W-1:0] lo, hi;
        for (int r = REG_COEF1; r <= REG_COEF5; r++) begin
            case (mode)
                0: begin lo = COEF_MAX; hi = COEF_MAX; end
                1: begin lo = COEF_MIN; hi = COEF_MIN; end
                2: begin lo = COEF_ONE; hi = COEF_MONE; end
                3: begin
                    lo = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                    hi = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
                end
                4: begin
                    lo = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
                    hi = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
                end
                default: begin lo = $urandom(); hi = $urandom(); end
            endcase
            add_cfg(r[IDX_W-1:0], {hi, lo});
        end
    endtask

    // Driver: hold an item until its transfer, then idle or advance
    always @(posedge i_clk) begin
        t_stim s;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_cfg_we     <= 1'b0;
            gap_left     <= 0;
            quiet_cycles <= 0;
        end else begin
            if (start && !busy)
                force_q.push_back(predict_force(i_pol_x, i_pol_y, i_pol_z));
            quiet_cycles <= start ? 0 : (quiet_cycles < 1000 ? quiet_cycles + 1 : 1000);

            if (start && busy) begin
                i_cfg_we <= 1'b0;
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                i_cfg_we <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (stim_q.size() == 0) begin
                start    <= 1'b0;
                i_cfg_we <= 1'b0;
            end else if (stim_q[0].is_cfg) begin
                start <= 1'b0;
                // Write only once the pipeline has drained
                if (!start && force_q.size() == 0 && quiet_cycles >= LATENCY + 2) begin
                    s = stim_q.pop_front();
                    i_cfg_we   <= 1'b1;
                    i_cfg_idx  <= s.idx;
                    i_cfg_data <= s.data;
                    if (s.idx == REG_SEL)
                        sel_shadow = s.data[1:0];
                    else if (s.idx <= REG_COEF5)
                        coef_shadow[s.idx] = s.data;
                end else begin
                    i_cfg_we <= 1'b0;
                end
            end else begin
                s = stim_q.pop_front();
                start    <= 1'b1;
                i_cfg_we <= 1'b0;
                i_pol_x  <= s.px;
                i_pol_y  <= s.py;
                i_pol_z  <= s.pz;
                gap_left <= s.gap;
            end
        end
    end

    // Monitor: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_force exp_f;
        if (i_rst_n && o_done) begin
            if (force_q.size() == 0) begin
                $error("result with no transfer pending: force_value %0d", o_force_value);
                n_errors++;
            end else begin
                exp_f = force_q.pop_front();
                if (o_force_value !== exp_f.value) begin
                    $error("force_value expected %0d actual %0d", exp_f.value, o_force_value);
                    n_errors++;
                end
                if (o_saturated_flag !== exp_f.sat) begin
                    $error("saturated_flag expected %0b actual %0b", exp_f.sat,
                           o_saturated_flag);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        logic signed [IN_W-1:0] corner[5];
        bit steady;
        corner = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF};

        // Directed: unit-ish coefficients, each selector, spares, extremes
        add_coef_set(2);
        add_cfg(REG_SPARE_LO, '1);
        add_cfg(REG_SPARE_HI, '1);
        for (int s = SEL_X; s <= SEL_NONE; s++) begin
            add_select(t_sel'(s));
            for (int k = 0; k < 5; k++)
                add_pol(corner[k], corner[(k + 1) % 5], corner[(k + 3) % 5], 0);
        end
        add_select(SEL_X);
        add_coef_set(0);
        add_pol(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
        add_pol(16'sh8000, 16'sh8000, 16'sh8000, 1);
        add_coef_set(1);
        add_pol(16'sh8000, 16'sh8000, 16'sh8000, 0);
        add_pol(16'sh7FFF, 16'sh8000, 16'sh7FFF, 2);

        // Random phases: new selector and coefficient set each time
        for (int ph = 0; ph < 10; ph++) begin
            add_select(t_sel'($urandom_range(SEL_X, SEL_NONE)));
            add_coef_set(ph < 6 ? ph : $urandom_range(3, 5));
            steady = 1'b0;
            for (int n = 0; n < 140; n++) begin
                if (n % 35 == 0) steady = $urandom_range(0, 2) == 0;
                add_pol(pick_pol(), pick_pol(), pick_pol(), pick_gap(steady));
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (stim_q.size() != 0 || start || force_q.size() != 0);
        repeat (LATENCY + 4) @(posedge i_clk);

        if (force_q.size() != 0) begin
            $error("%0d results never arrived", force_q.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/lpf_pkg.sv
hw/rtl/lpf_power.sv
hw/rtl/lpf_coef.sv
hw/rtl/lpf_sum.sv
hw/rtl/landau_polarization_force.sv
dv/tb_landau_polarization_force.sv
